@@ hdl/integer_block_sorter_core_defines.svh @@
// assertion macros for the block sorter
`ifndef INTEGER_BLOCK_SORTER_CORE_DEFINES_SVH
`define INTEGER_BLOCK_SORTER_CORE_DEFINES_SVH

// property must hold on every rising clock edge outside reset
`define IBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define IBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ibs_pkg.sv @@
`timescale 1ns / 1ps
package ibs_pkg;
  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } in_word_t;

  typedef struct packed {
    value_t sorted_value;
    logic   end_of_run;
    logic   overflow;
  } out_word_t;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
endpackage

@@ hdl/ibs_stream_if.sv @@
`timescale 1ns / 1ps
interface ibs_stream_if #(parameter int W = 34);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/integer_block_sorter_core.sv @@
//  channel | direction | word
//  in_     | sink      | value[31:0], last
//  out_    | source    | sorted_value[31:0], end_of_run, overflow
//  an item walks down from the top, moving each larger kept entry up a slot, until
//  an entry not larger or the bottom ends the walk and it is written; a full block drops it
//  a read-compare-shift loop walks down the single-port-read memory
//  the last item then drains n words, each read from memory and then registered
//  out_ has an output register; a stall holds the drain in place
//  reset clears count, flag and state; memory contents are not cleared
`timescale 1ns / 1ps
`include "integer_block_sorter_core_defines.svh"
module integer_block_sorter_core
  import ibs_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input logic clk,
  input logic rst_n,
  ibs_stream_if.sink   in_s,
  ibs_stream_if.source out_s
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  value_t        val_r, val_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic          rvalid_r, rvalid_nxt;
  out_word_t     ow_r, ow_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  value_t        wdata, rdata;
  in_word_t      iw;
  logic          in_fire, out_fire;

  assign iw       = in_word_t'(in_s.data);
  assign in_fire  = in_s.valid && in_s.ready;
  assign out_fire = out_s.valid && out_s.ready;
  assign in_s.ready  = (state_r == ST_LOAD);
  assign out_s.valid = ov_r;
  assign out_s.data  = ow_r;

  ibs_ram #(.DEPTH(ENTRIES), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; drop_nxt = drop_r;
    pos_nxt = pos_r; val_nxt = val_r; last_nxt = last_r;
    rd_nxt = rd_r; rvalid_nxt = 1'b0; ow_nxt = ow_r; ov_nxt = ov_r;
    we = 1'b0; waddr = pos_r[AW-1:0]; wdata = val_r; raddr = '0;
    if (out_fire) ov_nxt = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          val_nxt = iw.value; last_nxt = iw.last; pos_nxt = count_r;
          if (count_r == CW'(ENTRIES)) begin
            drop_nxt = 1'b1;
            if (iw.last) begin
              state_nxt = ST_DRAIN; rd_nxt = '0;
            end
          end else if (count_r == '0) begin
            state_nxt = ST_WRITE;
          end else begin
            raddr = AW'(count_r - CW'(1));
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // rdata holds entry pos-1
        if (val_r < rdata) begin
          we = 1'b1; waddr = pos_r[AW-1:0]; wdata = rdata;
          pos_nxt = pos_r - CW'(1);
          if (pos_r == CW'(1)) begin
            state_nxt = ST_WRITE;
          end else begin
            raddr = AW'(pos_r - CW'(2));
          end
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        we = 1'b1;
        count_nxt = count_r + CW'(1);
        if (last_r) begin
          state_nxt = ST_DRAIN; rd_nxt = '0;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_DRAIN: begin
        raddr = rd_r[AW-1:0];
        if (rvalid_r && (!ov_r || out_fire)) begin
          ov_nxt = 1'b1;
          ow_nxt.sorted_value = rdata;
          ow_nxt.end_of_run = (rd_r == count_r);
          ow_nxt.overflow = drop_r;
          if (rd_r == count_r) begin
            state_nxt = ST_LOAD; count_nxt = '0; drop_nxt = 1'b0; rd_nxt = '0;
          end
        end else if (!rvalid_r && rd_r < count_r) begin
          raddr = rd_r[AW-1:0];
          rd_nxt = rd_r + CW'(1);
          rvalid_nxt = 1'b1;
        end else if (rvalid_r) begin
          rvalid_nxt = 1'b1;
          raddr = AW'(rd_r - CW'(1));
        end else begin
          state_nxt = ST_LOAD; count_nxt = '0; drop_nxt = 1'b0; rd_nxt = '0;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; count_r <= '0; drop_r <= 1'b0;
      rvalid_r <= 1'b0; ov_r <= 1'b0; rd_r <= '0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; drop_r <= drop_nxt;
      rvalid_r <= rvalid_nxt; ov_r <= ov_nxt; rd_r <= rd_nxt;
    end
    pos_r <= pos_nxt; val_r <= val_nxt; last_r <= last_nxt; ow_r <= ow_nxt;
  end

  `IBS_ASSERT(a_count_range, count_r <= CW'(ENTRIES), "count beyond capacity")
  `IBS_ASSERT(a_ready_load, !in_s.ready || !out_s.valid || state_r == ST_LOAD,
              "ready outside load")
  `IBS_ASSERT_NEXT(a_write_grows, state_r == ST_WRITE,
                   count_r == $past(count_r) + CW'(1) || state_r == ST_DRAIN, "insert lost")
  `IBS_ASSERT(a_rd_bound, rd_r <= count_r, "drain index beyond count")
endmodule

@@ hdl/ibs_ram.sv @@
`timescale 1ns / 1ps
module ibs_ram
  import ibs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  value_t        wdata,
  input  logic [AW-1:0] raddr,
  output value_t        rdata
);
  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import ibs_pkg::*;

  localparam int ENTRIES = 64;

  logic clk;
  logic rst_n;

  ibs_stream_if #(.W(33)) in_s ();
  ibs_stream_if #(.W(34)) out_s ();

  integer_block_sorter_core #(.ENTRIES(ENTRIES)) DUT (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_s.sink),
    .out_s(out_s.source)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sorter state mirror
  value_t    held_vals[$];
  logic      dropped;
  out_word_t sorted_q[$];

  int errors;
  int words_in;
  int words_out;
  int runs_done;
  int send_idle_pct;
  int recv_idle_pct;

  typedef struct {
    value_t    value;
    logic      last;
    logic      has_exp;
    out_word_t exp_word;
  } stim_row_t;

  stim_row_t dir_tab[$];

  task automatic report_mismatch(input string what, input out_word_t got,
                                 input out_word_t want);
    $display("mismatch %s: got %0d/%0b/%0b want %0d/%0b/%0b", what,
             got.sorted_value, got.end_of_run, got.overflow,
             want.sorted_value, want.end_of_run, want.overflow);
    errors++;
  endtask

  function automatic void sort_word_in(input value_t v, input logic lst);
    int pos;
    out_word_t w;
    if (held_vals.size() >= ENTRIES) begin
      dropped = 1'b1;
    end else begin
      pos = held_vals.size();
      while (pos > 0 && v < held_vals[pos-1]) pos--;
      held_vals.insert(pos, v);
    end
    if (lst) begin
      foreach (held_vals[k]) begin
        w.sorted_value = held_vals[k];
        w.end_of_run = (k == held_vals.size() - 1);
        w.overflow = dropped;
        sorted_q.push_back(w);
      end
      held_vals.delete();
      dropped = 1'b0;
      runs_done++;
    end
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (rst_n && out_s.valid && out_s.ready) begin
      got = out_word_t'(out_s.data);
      words_out++;
      if (sorted_q.size() == 0) begin
        want = '0;
        report_mismatch("unexpected word", got, want);
      end else begin
        want = sorted_q.pop_front();
        if (got.sorted_value !== want.sorted_value) report_mismatch("value", got, want);
        if (got.end_of_run !== want.end_of_run) report_mismatch("end_of_run", got, want);
        if (got.overflow !== want.overflow) report_mismatch("overflow", got, want);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_s.ready <= 1'b0;
    end else begin
      out_s.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input value_t v, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_s.valid <= 1'b0;
      @(negedge clk);
    end
    in_s.valid <= 1'b1;
    in_s.data <= {v, lst};
    @(posedge clk);
    while (!in_s.ready) @(posedge clk);
    sort_word_in(v, lst);
    words_in++;
    @(negedge clk);
  endtask

  function automatic value_t rand_value(input int mode);
    case (mode)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return value_t'($urandom_range(6)) - 3;
      default: return value_t'($urandom());
    endcase
  endfunction

  task automatic send_run(input int len);
    int mode;
    for (int i = 0; i < len; i++) begin
      mode = ($urandom_range(9) < 2) ? $urandom_range(2) : 3;
      send_word(rand_value(mode), i == len - 1);
    end
  endtask

  task automatic add_row(input value_t v, input logic lst, input logic he,
                         input value_t ev, input logic eend, input logic eovf);
    stim_row_t r;
    r.value = v;
    r.last = lst;
    r.has_exp = he;
    r.exp_word.sorted_value = ev;
    r.exp_word.end_of_run = eend;
    r.exp_word.overflow = eovf;
    dir_tab.push_back(r);
  endtask

  task automatic run_phase(input int sidle, input int ridle, input int n_words);
    int sent;
    int len;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(9))
        0: len = ENTRIES + $urandom_range(1, 6);
        1: len = ENTRIES;
        2: len = 1;
        default: len = $urandom_range(2, 12);
      endcase
      send_run(len);
      sent += len;
    end
  endtask

  initial begin
    out_word_t chk;
    rst_n = 1'b0;
    in_s.valid = 1'b0;
    in_s.data = '0;
    out_s.ready = 1'b0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    runs_done = 0;
    dropped = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed runs: singles at extremes, duplicates, sign mix
    add_row(32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff, 1'b1, 1'b0);
    add_row(32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b1, 1'b0);
    add_row(0, 1'b1, 1'b1, 0, 1'b1, 1'b0);
    add_row(32'sh7fffffff, 1'b0, 1'b0, 0, 0, 0);
    add_row(32'sh80000000, 1'b0, 1'b0, 0, 0, 0);
    add_row(-1, 1'b0, 1'b0, 0, 0, 0);
    add_row(1, 1'b0, 1'b0, 0, 0, 0);
    add_row(-1, 1'b0, 1'b0, 0, 0, 0);
    add_row(0, 1'b1, 1'b0, 0, 0, 0);
    add_row(5, 1'b0, 1'b0, 0, 0, 0);
    add_row(5, 1'b0, 1'b0, 0, 0, 0);
    add_row(5, 1'b1, 1'b0, 0, 0, 0);
    add_row(32'sh55555555, 1'b0, 1'b0, 0, 0, 0);
    add_row(32'shaaaaaaaa, 1'b1, 1'b0, 0, 0, 0);
    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].value, dir_tab[i].last);
      if (dir_tab[i].has_exp) begin
        // predictor's view must agree with the hand-typed expectation
        chk = sorted_q[sorted_q.size()-1];
        if (chk !== dir_tab[i].exp_word) report_mismatch("table", chk, dir_tab[i].exp_word);
      end
    end
    // full capacity with the last three items dropped, then descending full run
    for (int i = 0; i < ENTRIES + 3; i++)
      send_word(value_t'($urandom()), i == ENTRIES + 2);
    for (int i = 0; i < ENTRIES; i++)
      send_word(ENTRIES - i, i == ENTRIES - 1);

    run_phase(17, 53, 80);
    run_phase(53, 17, 80);
    run_phase(0, 0, 80);
    in_s.valid <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d words sent in %0d runs, %0d sorted words checked",
             words_in, runs_done, words_out);
    if (errors == 0)
      $display("integer_block_sorter_core verification clean");
    else
      $display("integer_block_sorter_core verification failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("integer_block_sorter_core verification failed");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ibs_pkg.sv
hdl/ibs_stream_if.sv
hdl/ibs_ram.sv
hdl/integer_block_sorter_core.sv
dv/tb_top.sv
